>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define KQT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kqt assertion failed");

// property checked on every rising edge, reset included
`define KQT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kqt assertion failed");

`endif

>>> rtl/core/kqt_pkg.sv
// ----------------------------------------------------------------------------
// kqt_pkg
// shared types and constants of the keyed quantity table
// ----------------------------------------------------------------------------
package kqt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int QTY_W   = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EXISTS  = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] qty;
    } t_wr_req;

endpackage

>>> rtl/core/kqt_store.sv
// ----------------------------------------------------------------------------
// kqt_store
// key and quantity memories, one write port and one registered read port
// ----------------------------------------------------------------------------
module kqt_store (
    input  logic                         i_clk,
    input  kqt_pkg::t_wr_req             i_wr,
    input  logic [kqt_pkg::IDX_W-1:0]    i_rd_idx,
    output logic signed [kqt_pkg::KEY_W-1:0] o_rd_key,
    output logic signed [kqt_pkg::QTY_W-1:0] o_rd_qty
);
    import kqt_pkg::*;

    logic [KEY_W-1:0] r_key_mem [ENTRIES];
    logic [QTY_W-1:0] r_qty_mem [ENTRIES];
    logic [KEY_W-1:0] r_rd_key;
    logic [QTY_W-1:0] r_rd_qty;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_key_mem[i_wr.idx] <= i_wr.key;
            r_qty_mem[i_wr.idx] <= i_wr.qty;
        end
        r_rd_key <= r_key_mem[i_rd_idx];
        r_rd_qty <= r_qty_mem[i_rd_idx];
    end

    assign o_rd_key = $signed(r_rd_key);
    assign o_rd_qty = $signed(r_rd_qty);

endmodule

>>> rtl/core/kqt_alu.sv
// ----------------------------------------------------------------------------
// kqt_alu
// shared key compare and saturating quantity adder
// ----------------------------------------------------------------------------
module kqt_alu (
    input  logic signed [kqt_pkg::KEY_W-1:0] i_key_a,
    input  logic signed [kqt_pkg::KEY_W-1:0] i_key_b,
    input  logic signed [kqt_pkg::QTY_W-1:0] i_qty,
    input  logic signed [kqt_pkg::QTY_W-1:0] i_amt,
    output logic                             o_eq,
    output logic signed [kqt_pkg::QTY_W-1:0] o_sum
);
    import kqt_pkg::*;

    logic signed [QTY_W:0] w_sum;

    assign o_eq  = (i_key_a == i_key_b);
    assign w_sum = {i_qty[QTY_W-1], i_qty} + {i_amt[QTY_W-1], i_amt};

    always_comb begin
        if (w_sum[QTY_W] != w_sum[QTY_W-1]) begin
            // overflow: clamp toward the sign of the true sum
            o_sum = w_sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
        end else begin
            o_sum = w_sum[QTY_W-1:0];
        end
    end

endmodule

>>> rtl/core/keyed_quantity_table.sv
// ----------------------------------------------------------------------------
// keyed_quantity_table
// linear search key/quantity table with insert, search, update and list
// ----------------------------------------------------------------------------
// input stream: tuser carries the op, tdata carries part_key and amount.
// output stream: tuser carries the status, tdata carries key_out and
// quantity_out, tlast marks the final result of one input transfer.
// one input transfer is taken at a time; s_axis_tready is high only while
// the sequencer is idle, also while a result still waits at the output.
// insert, search and update walk the stored keys in insertion order, one
// key a cycle through the single read port of the store, and post the
// result from S_EMIT once the walk hits or reaches the end of the table.
// a full-table insert and an empty list go straight to S_EMIT, no walk.
// list reads one entry at a time, alternating S_LIST_RD and S_LIST_EMIT,
// and S_LIST_EMIT waits while the output register is not free.
// reset empties the table; store contents are left as they are.
// when the receiver stalls the result holds in the output register and the
// sequencer waits before posting the next one.
// ----------------------------------------------------------------------------
module keyed_quantity_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // part_key[31:0], amount[63:32]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // key_out[31:0], quantity_out[63:32]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast    // last
);
    import kqt_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_LIST_RD,
        S_LIST_EMIT,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [1:0]                r_op;
    logic signed [KEY_W-1:0]   r_key;
    logic signed [QTY_W-1:0]   r_amt;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_pend;
    logic [CNT_W-1:0]          r_count;
    logic [2:0]                r_res_status;
    logic signed [KEY_W-1:0]   r_res_key;
    logic signed [QTY_W-1:0]   r_res_qty;
    logic                      r_out_valid;
    logic [2:0]                r_out_status;
    logic signed [KEY_W-1:0]   r_out_key;
    logic signed [QTY_W-1:0]   r_out_qty;
    logic                      r_out_last;

    logic signed [KEY_W-1:0]   w_rd_key;
    logic signed [QTY_W-1:0]   w_rd_qty;
    logic                      w_eq;
    logic signed [QTY_W-1:0]   w_sum;
    logic                      w_hit;
    logic                      w_end;
    logic                      w_out_free;
    logic                      w_emit;
    logic                      w_in_xfer;
    logic [CNT_W-1:0]          w_prev_idx;
    logic [CNT_W-1:0]          w_next_idx;
    t_wr_req                   w_wr;

    kqt_store u_store (
        .i_clk    (i_clk),
        .i_wr     (w_wr),
        .i_rd_idx (r_idx[IDX_W-1:0]),
        .o_rd_key (w_rd_key),
        .o_rd_qty (w_rd_qty)
    );

    kqt_alu u_alu (
        .i_key_a (w_rd_key),
        .i_key_b (r_key),
        .i_qty   (w_rd_qty),
        .i_amt   (r_amt),
        .o_eq    (w_eq),
        .o_sum   (w_sum)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_emit        = ((r_state == S_EMIT) || (r_state == S_LIST_EMIT)) && w_out_free;
    assign w_hit         = r_pend && w_eq;
    assign w_end         = (r_idx == r_count);
    assign w_prev_idx    = r_idx - CNT_W'(1);
    assign w_next_idx    = r_idx + CNT_W'(1);

    // store writes: quantity update on an update hit, append on a missed insert
    always_comb begin
        w_wr.we  = 1'b0;
        w_wr.idx = r_count[IDX_W-1:0];
        w_wr.key = r_key;
        w_wr.qty = r_amt;
        if (r_state == S_SEARCH) begin
            if (w_hit) begin
                w_wr.we  = (r_op == OP_UPDATE);
                w_wr.idx = w_prev_idx[IDX_W-1:0];
                w_wr.qty = w_sum;
            end else if (w_end) begin
                w_wr.we  = (r_op == OP_INSERT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_op   <= s_axis_tuser;
                        r_key  <= $signed(s_axis_tdata[31:0]);
                        r_amt  <= $signed(s_axis_tdata[63:32]);
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (s_axis_tuser == OP_INSERT && r_count == CNT_W'(ENTRIES)) begin
                            r_res_status <= ST_FULL;
                            r_res_key    <= $signed(s_axis_tdata[31:0]);
                            r_res_qty    <= '0;
                            r_state      <= S_EMIT;
                        end else if (s_axis_tuser == OP_LIST && r_count == '0) begin
                            r_res_status <= ST_EMPTY;
                            r_res_key    <= '0;
                            r_res_qty    <= '0;
                            r_state      <= S_EMIT;
                        end else if (s_axis_tuser == OP_LIST) begin
                            r_state <= S_LIST_RD;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    r_res_key <= r_key;
                    if (w_hit) begin
                        r_pend  <= 1'b0;
                        r_state <= S_EMIT;
                        unique case (r_op)
                            OP_INSERT: begin
                                r_res_status <= ST_EXISTS;
                                r_res_qty    <= '0;
                            end
                            OP_UPDATE: begin
                                r_res_status <= ST_OK;
                                r_res_qty    <= w_sum;
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_res_qty    <= w_rd_qty;
                            end
                        endcase
                    end else if (w_end) begin
                        r_pend  <= 1'b0;
                        r_state <= S_EMIT;
                        if (r_op == OP_INSERT) begin
                            r_res_status <= ST_OK;
                            r_res_qty    <= r_amt;
                            r_count      <= r_count + CNT_W'(1);
                        end else begin
                            r_res_status <= ST_MISSING;
                            r_res_qty    <= '0;
                        end
                    end else begin
                        r_idx  <= w_next_idx;
                        r_pend <= 1'b1;
                    end
                end
                S_LIST_RD: begin
                    r_state <= S_LIST_EMIT;
                end
                S_LIST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_OK;
                        r_out_key    <= w_rd_key;
                        r_out_qty    <= w_rd_qty;
                        r_out_last   <= (w_next_idx == r_count);
                        if (w_next_idx == r_count) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= w_next_idx;
                            r_state <= S_LIST_RD;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_key    <= r_res_key;
                        r_out_qty    <= r_res_qty;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_qty, r_out_key};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    `KQT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(ENTRIES))
    `KQT_ASSERT(a_write_in_search, i_clk, i_rst_n, w_wr.we |-> (r_state == S_SEARCH))
    `KQT_ASSERT(a_busy_after_xfer, i_clk, i_rst_n, w_in_xfer |=> !s_axis_tready)
    `KQT_ASSERT(a_insert_has_room, i_clk, i_rst_n,
        (w_wr.we && r_op == OP_INSERT) |-> (r_count < CNT_W'(ENTRIES)))

endmodule
